// ----- src/hfam_pkg.sv -----
// ----------------------------------------------------------------------------
// hfam_pkg: shared types and constants for the half-float argmax core
// Payload structs, field masks and the half-precision ordering function.
// ----------------------------------------------------------------------------
package hfam_pkg;

   localparam int unsigned CodeWidth = 16;
   localparam int unsigned PosWidth  = 18;
   localparam longint unsigned MaxElements = 262144;
   localparam longint unsigned PosMask = (64'd1 << PosWidth) - 64'd1;
   localparam longint unsigned PosLimitWide =
      ((MaxElements - 64'd1) > PosMask) ? PosMask : (MaxElements - 64'd1);
   localparam logic [PosWidth-1:0] PosLimit = PosLimitWide[PosWidth-1:0];

   localparam logic [CodeWidth-1:0] ExpMask  = 16'h7C00;
   localparam logic [CodeWidth-1:0] FracMask = 16'h03FF;

   typedef struct packed {
      logic [CodeWidth-1:0] sample;
      logic                 final_req;
   } req_payload_type;

   typedef struct packed {
      logic [PosWidth-1:0]  winner_index;
      logic [CodeWidth-1:0] winner_value;
   } rsp_payload_type;

   function automatic logic is_nan(input logic [CodeWidth-1:0] c);
      return ((c & ExpMask) == ExpMask) && ((c & FracMask) != '0);
   endfunction

   // Strict IEEE greater-than on raw codes; NaN on either side is false.
   function automatic logic greater_than(input logic [CodeWidth-1:0] a,
                                         input logic [CodeWidth-1:0] b);
      logic signed [CodeWidth:0] ka;
      logic signed [CodeWidth:0] kb;
      ka = a[15] ? -$signed({2'b00, a[14:0]}) : $signed({2'b00, a[14:0]});
      kb = b[15] ? -$signed({2'b00, b[14:0]}) : $signed({2'b00, b[14:0]});
      return !is_nan(a) && !is_nan(b) && (ka > kb);
   endfunction

endpackage

// ----- src/half_float_argmax_core.sv -----
// ----------------------------------------------------------------------------
// half_float_argmax_core: streaming argmax over half-precision values
// Tracks the first strictly largest element of each vector.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one raw half code per transfer, final_req marks the last
//   element of a vector. rsp channel: one transfer per vector carrying the
//   winner's position and raw code.
//   Each element is compared against the running best combinationally, so
//   a new element is taken every cycle unless req_stall holds a final
//   element; the compare-and-update loop on the best register sets that rate.
//   The result appears in the rsp register the cycle after the
//   final element's transfer.
//   When the receiver stalls, the result holds in the rsp register; input
//   keeps flowing while no second result is pending, and req_stall rises
//   only when a final element arrives and the rsp register is still full.
//   Reset clears the running state and the rsp valid; the next element
//   starts a new vector.
// ----------------------------------------------------------------------------
module half_float_argmax_core import hfam_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [CodeWidth-1:0] best_code_ff, best_code_in;
   logic [PosWidth-1:0]  best_pos_ff, best_pos_in;
   logic [PosWidth-1:0]  pos_count_ff, pos_count_in;
   logic                 expect_first_ff, expect_first_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;
   logic                 req_take;
   logic                 rsp_free;

   // rsp register is free when empty or being drained this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // hold only a final element when its result has nowhere to go
   assign req_stall = req_payload.final_req && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      best_code_in    = best_code_ff;
      best_pos_in     = best_pos_ff;
      pos_count_in    = pos_count_ff;
      expect_first_in = expect_first_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_payload_in  = rsp_payload_ff;
      if (req_take) begin
         if (expect_first_ff) begin
            best_code_in = req_payload.sample;
            best_pos_in  = '0;
            pos_count_in = '0;
         end else begin
            // saturate the position at the limit
            if (pos_count_ff < PosLimit) begin
               pos_count_in = pos_count_ff + 1'b1;
            end
            if (greater_than(req_payload.sample, best_code_ff)) begin
               best_code_in = req_payload.sample;
               best_pos_in  = pos_count_in;
            end
         end
         expect_first_in = req_payload.final_req;
         if (req_payload.final_req) begin
            rsp_valid_in                = 1'b1;
            rsp_payload_in.winner_index = best_pos_in;
            rsp_payload_in.winner_value = best_code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_code_ff    <= '0;
         best_pos_ff     <= '0;
         pos_count_ff    <= '0;
         expect_first_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         best_code_ff    <= best_code_in;
         best_pos_ff     <= best_pos_in;
         pos_count_ff    <= pos_count_in;
         expect_first_ff <= expect_first_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
